@@ design/frm_pkg.sv @@
`default_nettype none

package frm_pkg;

  // field widths
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned RATE_W  = 24;

  // ring depth default
  localparam int unsigned DEPTH_DEF = 32;

  // rate numerator and window reset value
  localparam logic [RATE_W-1:0] RATE_NUM     = 24'd10000000;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd1000000;

  // divider step counter, holds up to STAMP_W
  localparam int unsigned DIV_CNT_W = $clog2(STAMP_W + 1);

  // per-cell control: load shifts a new stamp in, rotate walks the row
  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctl_t;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/frm_cell.sv @@
`default_nettype none

module frm_cell (
  input  logic                         clk_i,
  input  frm_pkg::cell_ctl_t           ctl_i,
  input  logic [frm_pkg::STAMP_W-1:0]  left_i,
  input  logic [frm_pkg::STAMP_W-1:0]  right_i,
  output logic [frm_pkg::STAMP_W-1:0]  q_o
);
  import frm_pkg::*;

  logic [STAMP_W-1:0] stamp_q;

  // new item shifts in from the left, walk rotates in from the right
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      stamp_q <= left_i;
    end else if (ctl_i.rotate) begin
      stamp_q <= right_i;
    end
  end

  assign q_o = stamp_q;

endmodule

`default_nettype wire

@@ design/frm_div.sv @@
`default_nettype none

module frm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frm_pkg::div_req_t            req_i,
  input  logic [frm_pkg::STAMP_W-1:0]  num_i,
  input  logic [frm_pkg::STAMP_W-1:0]  den_i,
  output frm_pkg::div_rsp_t            rsp_o,
  output logic [frm_pkg::STAMP_W-1:0]  quo_o
);
  import frm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [STAMP_W-1:0]   rem_q, rem_d;
  logic [STAMP_W-1:0]   quo_q, quo_d;
  logic [STAMP_W-1:0]   den_q, den_d;
  logic [STAMP_W:0]     shifted;
  logic [STAMP_W:0]     diff;
  logic                 fits;

  // one restoring step: bring down the next numerator bit, try subtract
  assign shifted = {rem_q, quo_q[STAMP_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
      quo_d = {quo_q[STAMP_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

@@ design/frame_rate_meter.sv @@
// channel   | valid       | stall        | payload
// ----------+-------------+--------------+--------------------------------
// input     | in_valid_i  | in_stall_o   | timestamp_us_i
// output    | out_valid_o | out_stall_i  | rate_x10_o, rate_valid_o
// config    | cfg_window_we_i (no stall)  | cfg_window_us_i
//
// an item before the ring has filled goes straight to the result hand-off with a zero, not-valid rate
// once filled, an item takes a walk rotating the cell row, then span / intervals
// and 10^7 / average in the shared bit-serial divider, then the result hand-off
// a zero average interval skips the second division
// the input is stalled from acceptance until the result enters the output register
// a stalled result holds in the output register; the next item waits for it
// reset clears control state and sets window_us to 1000000; stamps are not reset
`default_nettype none

module frame_rate_meter #(
  parameter int unsigned DEPTH = frm_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [frm_pkg::STAMP_W-1:0]  timestamp_us_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [frm_pkg::RATE_W-1:0]   rate_x10_o,
  output logic                         rate_valid_o,
  input  logic                         cfg_window_we_i,
  input  logic [frm_pkg::WIN_W-1:0]    cfg_window_us_i
);
  import frm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [WIN_W-1:0]    window_q;
  logic [CW-1:0]       slot_q, slot_d;
  logic                filled_q, filled_d;
  logic [CW-1:0]       walk_q, walk_d;
  logic                found_q, found_d;
  logic [STAMP_W-1:0]  newest_q, newest_d;
  logic [STAMP_W-1:0]  span_q, span_d;
  logic [CW-1:0]       ivl_q, ivl_d;
  logic [RATE_W-1:0]   res_rate_q, res_rate_d;
  logic                res_valid_q, res_valid_d;
  logic                out_valid_q;
  logic [RATE_W-1:0]   out_rate_q;
  logic                out_rvalid_q;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                walk_last;
  logic [STAMP_W-1:0]  span;
  logic                over;
  cell_ctl_t           cell_ctl;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [STAMP_W-1:0]  div_num;
  logic [STAMP_W-1:0]  div_den;
  logic [STAMP_W-1:0]  div_quo;
  logic [STAMP_W-1:0]  cell_q [DEPTH];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign walk_last  = (walk_q == CW'(DEPTH - 1));

  // row of stamp cells, newest in cell 0
  assign cell_ctl.load   = in_acc;
  assign cell_ctl.rotate = (state_q == S_WALK);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [STAMP_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = timestamp_us_i;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[0];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    frm_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[i])
    );
  end

  // span from the newest stamp to the entry now at the head of the row
  assign span = newest_q - cell_q[0];
  assign over = span > {{(STAMP_W - WIN_W){1'b0}}, window_q};

  // shared divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = DIV_CNT_W'(STAMP_W);
    div_num       = span_q;
    div_den       = {{(STAMP_W - CW){1'b0}}, ivl_q};
    if (state_q == S_WALK && walk_last) begin
      // the oldest entry may be chosen in this very cycle
      div_req.start = 1'b1;
      div_num       = span_d;
      div_den       = {{(STAMP_W - CW){1'b0}}, ivl_d};
    end else if (state_q == S_DIV1 && div_rsp.done && div_quo != '0) begin
      div_req.start = 1'b1;
      div_req.steps = DIV_CNT_W'(RATE_W);
      div_num       = {RATE_NUM, {(STAMP_W - RATE_W){1'b0}}};
      div_den       = div_quo;
    end
  end

  frm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp),
    .quo_o  (div_quo)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    filled_d    = filled_q;
    walk_d      = walk_q;
    found_d     = found_q;
    newest_d    = newest_q;
    span_d      = span_q;
    ivl_d       = ivl_q;
    res_rate_d  = res_rate_q;
    res_valid_d = res_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          newest_d = timestamp_us_i;
          walk_d   = '0;
          found_d  = 1'b0;
          if (slot_q == CW'(DEPTH - 1)) begin
            slot_d   = '0;
            filled_d = 1'b1;
          end else begin
            slot_d = slot_q + CW'(1);
          end
          if (filled_q || slot_q == CW'(DEPTH - 1)) begin
            state_d = S_WALK;
          end else begin
            res_rate_d  = '0;
            res_valid_d = 1'b0;
            state_d     = S_DONE;
          end
        end
      end
      S_WALK: begin
        // first entry past the window, else the oldest
        if (walk_q != '0 && !found_q && (over || walk_last)) begin
          found_d = 1'b1;
          span_d  = span;
          ivl_d   = walk_q;
        end
        walk_d = walk_q + CW'(1);
        if (walk_last) begin
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          if (div_quo == '0) begin
            res_rate_d  = RATE_NUM;
            res_valid_d = 1'b1;
            state_d     = S_DONE;
          end else begin
            state_d = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          res_rate_d  = div_quo[RATE_W-1:0];
          res_valid_d = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WINDOW_RESET;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      walk_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
      walk_q   <= walk_d;
      found_q  <= found_d;
      if (cfg_window_we_i) begin
        window_q <= cfg_window_us_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    newest_q    <= newest_d;
    span_q      <= span_d;
    ivl_q       <= ivl_d;
    res_rate_q  <= res_rate_d;
    res_valid_q <= res_valid_d;
    if (out_load) begin
      out_rate_q   <= res_rate_q;
      out_rvalid_q <= res_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rate_x10_o   = out_rate_q;
  assign rate_valid_o = out_rvalid_q;

  // an accepted item closes the input the next cycle
  a_acc_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input open right after an item was taken");

  // the walk always settles on an entry
  a_walk_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && walk_last) |=> found_q)
    else $error("walk ended without a chosen entry");

  // divider finishes only while a division is awaited
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider done outside a division state");

  // a division starts only on an idle divider
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a not-valid result carries a zero rate
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rate_valid_o) |-> (rate_x10_o == '0))
    else $error("nonzero rate on a not-valid result");

endmodule

`default_nettype wire

@@ bench/frame_rate_meter_tb.sv @@
`timescale 1ns / 100ps

module frame_rate_meter_tb;
  import frm_pkg::*;

  localparam int unsigned RING_DEPTH     = 32;
  localparam int unsigned SLOT_W         = $clog2(RING_DEPTH);
  localparam logic [RATE_W-1:0] RATE_CEIL      = 24'd10_000_000;
  localparam logic [WIN_W-1:0]  WINDOW_DEFAULT = 32'd1_000_000;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = RING_DEPTH + 100;
  localparam int unsigned CHUNK_ITEMS    = 68;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_x10;
    logic              rate_valid;
  } rate_t;

  typedef enum int unsigned {
    WIN_ZERO, WIN_ONE, WIN_MAX, WIN_DEFAULT, WIN_SHORT, WIN_ANY
  } win_pick_e;

  typedef enum int unsigned {
    PACE_TINY, PACE_VIDEO, PACE_SLOW, PACE_WILD
  } pace_e;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  stamp_t            stamp      = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [RATE_W-1:0] rate_x10;
  logic              rate_valid;
  logic              cfg_we     = 1'b0;
  logic [WIN_W-1:0]  cfg_window = '0;

  // predictor state
  stamp_t           ring_model [RING_DEPTH];
  slot_t            slot_model   = '0;
  logic             filled_model = 1'b0;
  logic [WIN_W-1:0] window_model = WINDOW_DEFAULT;

  stamp_t      stamps_to_send [$];
  rate_t       rates_due [$];
  stamp_t      frame_clock   = '0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 60;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  frame_rate_meter #(
    .DEPTH(RING_DEPTH)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .timestamp_us_i (stamp),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .rate_x10_o     (rate_x10),
    .rate_valid_o   (rate_valid),
    .cfg_window_we_i(cfg_we),
    .cfg_window_us_i(cfg_window)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // store the stamp, walk back past the window or to the oldest, derive the rate
  function automatic rate_t predict_rate(input stamp_t newest);
    slot_t       newest_slot;
    stamp_t      span;
    stamp_t      avg;
    stamp_t      quotient;
    int unsigned intervals;
    rate_t       r;
    newest_slot = slot_model;
    ring_model[newest_slot] = newest;
    slot_model = slot_model + 1'b1;
    if (slot_model == '0) filled_model = 1'b1;
    r = '0;
    if (filled_model) begin
      intervals = 1;
      span = newest - ring_model[slot_t'(newest_slot - slot_t'(intervals))];
      while (span <= stamp_t'(window_model) && intervals < RING_DEPTH - 1) begin
        intervals++;
        span = newest - ring_model[slot_t'(newest_slot - slot_t'(intervals))];
      end
      avg = span / stamp_t'(intervals);
      // zero average interval saturates
      quotient = (avg == '0) ? stamp_t'(RATE_CEIL) : stamp_t'(RATE_CEIL) / avg;
      r.rate_x10   = quotient[RATE_W-1:0];
      r.rate_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case (win_pick_e'($urandom_range(WIN_ANY)))
      WIN_ZERO:    return '0;
      WIN_ONE:     return 32'd1;
      WIN_MAX:     return '1;
      WIN_DEFAULT: return WINDOW_DEFAULT;
      WIN_SHORT:   return $urandom_range(200_000);
      default:     return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_period();
    case (pace_e'($urandom_range(PACE_WILD)))
      PACE_TINY:  return $urandom_range(3);
      PACE_VIDEO: return $urandom_range(40_000, 5_000);
      PACE_SLOW:  return $urandom_range(400_000, 40_000);
      default:    return $urandom_range(1 << 24, 1);
    endcase
  endfunction

  // mostly steady frames with jitter, then repeats, strays, steps back, big jumps
  function automatic stamp_t next_stamp(input int unsigned period);
    int unsigned pick;
    logic [63:0] noise;
    logic [15:0] jump_hi;
    pick    = $urandom_range(99);
    noise   = {$urandom, $urandom};
    jump_hi = 16'($urandom_range(16'hFFFF));
    if (pick < 75) begin
      frame_clock = frame_clock + stamp_t'(period)
                  + stamp_t'((period >= 8) ? $urandom_range(period >> 3) : 0);
    end else if (pick < 83) begin
      // repeated frame time
    end else if (pick < 90) begin
      return noise[STAMP_W-1:0];
    end else if (pick < 95) begin
      frame_clock = frame_clock - stamp_t'($urandom_range(1000));
    end else begin
      frame_clock = frame_clock + {jump_hi, 32'($urandom)};
    end
    return frame_clock;
  endfunction

  // hold off until the block has returned everything
  task automatic wait_idle();
    do @(posedge clk);
    while (stamps_to_send.size() != 0 || in_valid || rates_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_window   <= value;
    window_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) rates_due.push_back(predict_rate(stamp));
      if (!in_valid || !in_stall) begin
        if (stamps_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          stamp    <= stamps_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rate_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rates_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, rate_x10 %0d rate_valid %0b",
                   $time, rate_x10, rate_valid);
        end else begin
          want = rates_due.pop_front();
          if (rate_x10 !== want.rate_x10) begin
            mismatches++;
            $display("%0t: rate_x10 expected %0d, actual %0d",
                     $time, want.rate_x10, rate_x10);
          end
          if (rate_valid !== want.rate_valid) begin
            mismatches++;
            $display("%0t: rate_valid expected %0b, actual %0b",
                     $time, want.rate_valid, rate_valid);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("frame_rate_meter_tb NOT OK");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned period;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // fill the ring at the reset window, crossing the 48-bit wrap
    frame_clock = '1 - stamp_t'(16_000);
    for (int i = 0; i < RING_DEPTH; i++) begin
      frame_clock = frame_clock + stamp_t'(1000);
      stamps_to_send.push_back(frame_clock);
    end

    // zero window: one-step span, then a zero average interval
    wait_idle();
    write_window('0);
    frame_clock = frame_clock + 1'b1;
    stamps_to_send.push_back(frame_clock);
    stamps_to_send.push_back(frame_clock);

    // widest window: step back, half-range jump, all ones, all zeros
    wait_idle();
    write_window('1);
    stamps_to_send.push_back(frame_clock - stamp_t'(5));
    stamps_to_send.push_back(frame_clock + {1'b1, {(STAMP_W-1){1'b0}}});
    stamps_to_send.push_back('1);
    stamps_to_send.push_back('0);

    // random frame streams under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      for (int chunk = 0; chunk < 4; chunk++) begin
        wait_idle();
        if (chunk == 0) begin
          send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 60 : 0;
          recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 37 : 0;
        end
        write_window((phase == 0 && chunk == 0) ? 32'd1 : pick_window());
        period = pick_period();
        for (int i = 0; i < CHUNK_ITEMS; i++) stamps_to_send.push_back(next_stamp(period));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rates_due.size() == 0) begin
      $display("frame_rate_meter_tb OK");
    end else begin
      $display("frame_rate_meter_tb NOT OK");
    end
    $finish;
  end

endmodule
